/* src/b64sc_pkg.sv */
`timescale 1ns / 1ps

package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       bad_char;
    } out_item_t;

    typedef enum logic [1:0] {
        CH_DATA,
        CH_PAD,
        CH_BAD
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [5:0] value;
    } char_info_t;

    // 6-bit group to standard alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26) begin
                c = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52) begin
                c = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62) begin
                c = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62) begin
                c = 8'h2B;
            end
            else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

    // character to 6-bit group, pad or bad
    function automatic char_info_t dec_char(input logic [7:0] c);
        char_info_t r;
        begin
            r.kind  = CH_DATA;
            r.value = 6'd0;
            if (c >= 8'h41 && c <= 8'h5A) begin
                r.value = 6'(c - 8'h41);
            end
            else if (c >= 8'h61 && c <= 8'h7A) begin
                r.value = 6'(c - 8'h61 + 8'd26);
            end
            else if (c >= 8'h30 && c <= 8'h39) begin
                r.value = 6'(c - 8'h30 + 8'd52);
            end
            else if (c == 8'h2B) begin
                r.value = 6'd62;
            end
            else if (c == 8'h2F) begin
                r.value = 6'd63;
            end
            else if (c == PAD_CHAR) begin
                r.kind = CH_PAD;
            end
            else begin
                r.kind = CH_BAD;
            end
            return r;
        end
    endfunction

endpackage

/* src/base64_stream_codec.sv */
`timescale 1ns / 1ps

// streaming base64 codec, standard alphabet with '=' padding
// channels: in (valid/ready, byte or character plus last flag), out
// (valid/ready, character or byte plus last and bad_char flags), cfg
// (valid/ready, one bit: 0 encode, 1 decode); a cfg write clears the stream
// state and is meant to happen only while the block is idle
// each accepted request is worked out combinationally into a small result list
// of up to four entries; the list drains one entry per cycle through its single
// read port into the output register, while that register is free
// the first result of a request passes the result list, then the output
// register, before it is on out; throughput: one request per cycle when it
// makes at most one result (all of decode, some of encode) and the receiver
// does not stall, else the next request waits until the list is down to its
// last entry; an encode byte makes 1 or 2 results, a final one with padding up to 4
// reset: mode is encode, stream state empty, no result pending
// receiver stall: the output register holds its request, the list stops
// draining and in_ready stays low while the list holds any entry
module base64_stream_codec
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b64sc_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output b64sc_pkg::out_item_t  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    // stream state
    logic        mode_reg, mode_next;
    logic [15:0] bits_reg, bits_next;
    logic [4:0]  bit_cnt_reg, bit_cnt_next;
    logic [1:0]  phase_reg, phase_next;

    // result list waiting for the output register
    logic [7:0]  pend_data_reg [b64sc_pkg::MAX_RESULTS];
    logic [7:0]  pend_data_next [b64sc_pkg::MAX_RESULTS];
    logic [2:0]  pend_left_reg, pend_left_next;
    logic        pend_last_reg, pend_last_next;
    logic        pend_bad_reg, pend_bad_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    b64sc_pkg::out_item_t  out_reg, out_next;

    // results of the current request
    logic [7:0]  res_data [b64sc_pkg::MAX_RESULTS];
    logic [2:0]  res_num;
    logic        res_last;
    logic        res_bad;

    logic        in_fire;
    logic        cfg_fire;
    logic        pop;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // move the list head into the output register when it is free
    assign pop      = (pend_left_reg != 3'd0) && (!out_valid_reg || out_ready);
    // take a request when the list is empty or empties this cycle
    assign in_ready = (pend_left_reg == 3'd0) || ((pend_left_reg == 3'd1) && pop);
    assign in_fire  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // per-request work
    always_comb
    begin
        logic [15:0]          enc_bits;
        logic [5:0]           main_val [2];
        logic [1:0]           main_num;
        logic [4:0]           left_cnt;
        logic [5:0]           left_val;
        logic [2:0]           tot;
        logic [1:0]           phase_end;
        logic [1:0]           pads;
        logic [15:0]          dec_bits;
        logic [4:0]           dec_cnt;
        b64sc_pkg::char_info_t info;

        mode_next    = mode_reg;
        bits_next    = bits_reg;
        bit_cnt_next = bit_cnt_reg;
        phase_next   = phase_reg;
        for (int i = 0; i < b64sc_pkg::MAX_RESULTS; i++) begin
            res_data[i] = 8'd0;
        end
        res_num  = 3'd0;
        res_last = 1'b0;
        res_bad  = 1'b0;

        enc_bits    = {bits_reg[7:0], in_data.data_in};
        main_val[0] = enc_bits[7:2];
        main_val[1] = 6'd0;
        main_num    = 2'd1;
        left_cnt    = 5'd2;
        left_val    = {enc_bits[1:0], 4'b0000};
        // pending bit count before the byte is 0, 2 or 4
        case (bit_cnt_reg[2:1])
            2'd1:
            begin
                main_val[0] = enc_bits[9:4];
                left_cnt    = 5'd4;
                left_val    = {enc_bits[3:0], 2'b00};
            end
            2'd2:
            begin
                main_val[0] = enc_bits[11:6];
                main_val[1] = enc_bits[5:0];
                main_num    = 2'd2;
                left_cnt    = 5'd0;
                left_val    = 6'd0;
            end
            default:
            begin
                main_val[0] = enc_bits[7:2];
            end
        endcase
        tot       = {1'b0, main_num} + {2'b00, (left_cnt != 5'd0)};
        phase_end = phase_reg + tot[1:0];
        pads      = 2'd0 - phase_end;

        info     = b64sc_pkg::dec_char(in_data.data_in);
        dec_bits = {bits_reg[9:0], info.value};
        dec_cnt  = bit_cnt_reg + 5'd6;

        if (cfg_fire) begin
            mode_next    = cfg_data;
            bits_next    = 16'd0;
            bit_cnt_next = 5'd0;
            phase_next   = 2'd0;
        end
        else if (in_fire) begin
            if (!mode_reg) begin
                // encode: main characters, then leftover and padding on last
                for (int i = 0; i < b64sc_pkg::MAX_RESULTS; i++) begin
                    if (3'(i) < {1'b0, main_num}) begin
                        res_data[i] = b64sc_pkg::enc_char(main_val[i[0]]);
                    end
                    else if ((3'(i) == {1'b0, main_num}) && (left_cnt != 5'd0)) begin
                        res_data[i] = b64sc_pkg::enc_char(left_val);
                    end
                    else begin
                        res_data[i] = b64sc_pkg::PAD_CHAR;
                    end
                end
                res_last = in_data.last_in;
                if (in_data.last_in) begin
                    res_num      = tot + {1'b0, pads};
                    bits_next    = 16'd0;
                    bit_cnt_next = 5'd0;
                    phase_next   = 2'd0;
                end
                else begin
                    res_num      = {1'b0, main_num};
                    bits_next    = enc_bits;
                    bit_cnt_next = left_cnt;
                    phase_next   = phase_reg + main_num;
                end
            end
            else begin
                res_last = 1'b1;
                case (info.kind)
                    b64sc_pkg::CH_BAD:
                    begin
                        res_num = 3'd1;
                        res_bad = 1'b1;
                    end
                    b64sc_pkg::CH_DATA:
                    begin
                        bits_next    = dec_bits;
                        bit_cnt_next = dec_cnt;
                        phase_next   = phase_reg + 2'd1;
                        if (dec_cnt >= 5'd8) begin
                            res_data[0]  = 8'(dec_bits >> (dec_cnt - 5'd8));
                            bit_cnt_next = dec_cnt - 5'd8;
                            res_num      = 3'd1;
                        end
                    end
                    default:
                    begin
                        res_num = 3'd0;
                    end
                endcase
                if (in_data.last_in) begin
                    bits_next    = 16'd0;
                    bit_cnt_next = 5'd0;
                    phase_next   = 2'd0;
                end
            end
        end
    end

    // result list and output register
    always_comb
    begin
        pend_left_next = pend_left_reg;
        pend_last_next = pend_last_reg;
        pend_bad_next  = pend_bad_reg;
        for (int i = 0; i < b64sc_pkg::MAX_RESULTS; i++) begin
            pend_data_next[i] = pend_data_reg[i];
        end
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (pop) begin
            out_valid_next    = 1'b1;
            out_next.data_out = pend_data_reg[0];
            out_next.last_out = pend_last_reg && (pend_left_reg == 3'd1);
            out_next.bad_char = pend_bad_reg;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (in_fire) begin
            pend_left_next = res_num;
            pend_last_next = res_last;
            pend_bad_next  = res_bad;
            for (int i = 0; i < b64sc_pkg::MAX_RESULTS; i++) begin
                pend_data_next[i] = res_data[i];
            end
        end
        else if (pop) begin
            pend_left_next = pend_left_reg - 3'd1;
            for (int i = 0; i < b64sc_pkg::MAX_RESULTS - 1; i++) begin
                pend_data_next[i] = pend_data_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= 1'b0;
            bits_reg      <= 16'd0;
            bit_cnt_reg   <= 5'd0;
            phase_reg     <= 2'd0;
            pend_left_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            mode_reg      <= mode_next;
            bits_reg      <= bits_next;
            bit_cnt_reg   <= bit_cnt_next;
            phase_reg     <= phase_next;
            pend_left_reg <= pend_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pend_last_reg <= pend_last_next;
        pend_bad_reg  <= pend_bad_next;
        out_reg       <= out_next;
        for (int i = 0; i < b64sc_pkg::MAX_RESULTS; i++) begin
            pend_data_reg[i] <= pend_data_next[i];
        end
    end

endmodule

/* bench/tb_base64_stream_codec.sv */
`timescale 1ns / 1ps

// codes returned by the character lookup besides the sextet values 0..63
localparam int SEXTET_PAD = 64;
localparam int SEXTET_BAD = 65;

// mirror of the codec stream state and the ordered list of results it owes
class b64_stream_shadow;
    string                 alphabet;
    bit                    decode_mode;
    logic [15:0]           bit_buf;
    int unsigned           bit_cnt;
    logic [1:0]            group_phase;
    b64sc_pkg::out_item_t  coded_q[$];
    int                    errors;

    function new();
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        errors   = 0;
        set_mode(1'b0);
    endfunction

    function void clear_stream();
        bit_buf     = '0;
        bit_cnt     = 0;
        group_phase = '0;
    endfunction

    // a mode write also empties the stream state
    function void set_mode(input bit m);
        decode_mode = m;
        clear_stream();
    endfunction

    function logic [7:0] sextet_char(input logic [5:0] v);
        return alphabet[v];
    endfunction

    function int char_sextet(input logic [7:0] c);
        if (c == b64sc_pkg::PAD_CHAR)
            return SEXTET_PAD;
        for (int i = 0; i < 64; i++)
        begin
            if (alphabet[i] == c)
                return i;
        end
        return SEXTET_BAD;
    endfunction

    function void push_result(input logic [7:0] d, input logic l, input logic b);
        b64sc_pkg::out_item_t r;
        r.data_out = d;
        r.last_out = l;
        r.bad_char = b;
        coded_q.push_back(r);
    endfunction

    function void note_request(input b64sc_pkg::in_item_t req);
        logic [15:0]           window;
        int                    code;
        b64sc_pkg::out_item_t  tail;
        if (!decode_mode)
        begin
            bit_buf = {bit_buf[7:0], req.data_in};
            bit_cnt += 8;
            while (bit_cnt >= 6)
            begin
                window = bit_buf >> (bit_cnt - 6);
                push_result(sextet_char(window[5:0]), 1'b0, 1'b0);
                bit_cnt -= 6;
                group_phase++;
            end
            if (req.last_in)
            begin
                // leftover bits zero filled into one more character
                if (bit_cnt > 0)
                begin
                    window = bit_buf << (6 - bit_cnt);
                    push_result(sextet_char(window[5:0]), 1'b0, 1'b0);
                    group_phase++;
                end
                while (group_phase != 0)
                begin
                    push_result(b64sc_pkg::PAD_CHAR, 1'b0, 1'b0);
                    group_phase++;
                end
                tail = coded_q.pop_back();
                tail.last_out = 1'b1;
                coded_q.push_back(tail);
                clear_stream();
            end
        end
        else
        begin
            code = char_sextet(req.data_in);
            if (code == SEXTET_BAD)
                push_result(8'h00, 1'b1, 1'b1);
            else if (code != SEXTET_PAD)
            begin
                bit_buf = {bit_buf[9:0], code[5:0]};
                bit_cnt += 6;
                group_phase++;
                if (bit_cnt >= 8)
                begin
                    window = bit_buf >> (bit_cnt - 8);
                    bit_cnt -= 8;
                    push_result(window[7:0], 1'b1, 1'b0);
                end
            end
            if (req.last_in)
                clear_stream();
        end
    endfunction

    function void check_result(input b64sc_pkg::out_item_t got);
        b64sc_pkg::out_item_t want;
        if (coded_q.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual data %h last %b bad %b",
                     $time, got.data_out, got.last_out, got.bad_char);
            errors++;
            return;
        end
        want = coded_q.pop_front();
        if (got.data_out !== want.data_out)
        begin
            $display("%0t: data_out mismatch: expected %h, actual %h",
                     $time, want.data_out, got.data_out);
            errors++;
        end
        if (got.last_out !== want.last_out)
        begin
            $display("%0t: last_out mismatch: expected %b, actual %b",
                     $time, want.last_out, got.last_out);
            errors++;
        end
        if (got.bad_char !== want.bad_char)
        begin
            $display("%0t: bad_char mismatch: expected %b, actual %b",
                     $time, want.bad_char, got.bad_char);
            errors++;
        end
    endfunction
endclass

module tb_base64_stream_codec;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 400;
    // receiver hold long enough to back the block up into its input
    localparam int LONG_HOLD    = 300;
    // quiet cycles after the last owed result; covers a pad request still in flight
    localparam int SETTLE       = 8;
    localparam int TIMEOUT_NS   = 300000 * CLK_PERIOD;

    // receiver stall patterns
    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    b64sc_pkg::in_item_t   in_data;
    logic                  out_valid;
    logic                  out_ready;
    b64sc_pkg::out_item_t  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_data;

    b64_stream_shadow shadow;

    // sender burst bookkeeping and request count
    int burst_left    = 0;
    int requests_sent = 0;
    // raised by the stimulus, served and cleared by the receiver process
    bit hold_req      = 1'b0;

    base64_stream_codec u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // offer one request; bursts of random length with random gaps in between
    task automatic offer_item(input logic [7:0] d, input logic l);
        b64sc_pkg::in_item_t req;
        int                  gap;
        req.data_in = d;
        req.last_in = l;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.note_request(req);
        requests_sent++;
    endtask

    // stop sending and wait until every owed result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (shadow.coded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // mode write, only with the block idle
    task automatic write_mode(input logic m);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow.set_mode(m);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_encode_msg(input int nbytes, input bit with_last);
        for (int i = 0; i < nbytes; i++)
            offer_item(8'($urandom_range(0, 255)), with_last && (i == nbytes - 1));
    endtask

    // well formed base64 text of random bytes, optionally corrupted or cut short
    task automatic send_decode_msg(input int nbytes, input bit with_last, input bit noisy);
        logic [7:0]  text[$];
        logic [23:0] grp;
        int          take;
        int          cut;
        for (int i = 0; i < nbytes; i += 3)
        begin
            take = (nbytes - i >= 3) ? 3 : nbytes - i;
            grp  = 24'($urandom);
            // bits past the message end are zero in proper text
            if (take < 3)
                grp[7:0] = 8'h00;
            if (take < 2)
                grp[15:8] = 8'h00;
            for (int k = 0; k < 4; k++)
                text.push_back(k <= take ? shadow.sextet_char(grp[23 - 6 * k -: 6])
                                         : b64sc_pkg::PAD_CHAR);
        end
        if (noisy)
        begin
            // stray pads and arbitrary bytes, many of them outside the alphabet
            foreach (text[j])
            begin
                if ($urandom_range(0, 7) == 0)
                    text[j] = ($urandom_range(0, 2) == 0) ? b64sc_pkg::PAD_CHAR
                                                         : 8'($urandom_range(0, 255));
            end
            cut = $urandom_range(0, 3);
            while (cut > 0 && text.size() > 1)
            begin
                void'(text.pop_back());
                cut--;
            end
        end
        foreach (text[j])
            offer_item(text[j], with_last && (j == text.size() - 1));
    endtask

    initial
    begin : stimulus
        int phase_no;
        int phase_len;
        int phase_start;
        int random_base;
        bit phase_mode;
        shadow    = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // encode from reset: messages of one to four bytes cover every pad count,
        // the all-zero and all-one bytes and the '+' and '/' characters
        offer_item(8'h00, 1'b1);
        offer_item(8'hFF, 1'b0);
        offer_item(8'h00, 1'b1);
        offer_item(8'hFB, 1'b0);
        offer_item(8'hEF, 1'b0);
        offer_item(8'hBE, 1'b1);
        offer_item(8'hFF, 1'b0);
        offer_item(8'hFF, 1'b0);
        offer_item(8'hFF, 1'b0);
        offer_item(8'h80, 1'b1);

        // decode: alphabet range ends, bad characters next to the ranges,
        // pad inside a group, pad carrying last, bad character carrying last
        write_mode(1'b1);
        offer_item("A", 1'b0);
        offer_item("Z", 1'b0);
        offer_item("a", 1'b0);
        offer_item("z", 1'b0);
        offer_item("0", 1'b0);
        offer_item("9", 1'b0);
        offer_item("+", 1'b0);
        offer_item("/", 1'b0);
        offer_item("@", 1'b0);
        offer_item("{", 1'b0);
        offer_item("Q", 1'b0);
        offer_item(b64sc_pkg::PAD_CHAR, 1'b0);
        offer_item(b64sc_pkg::PAD_CHAR, 1'b1);
        offer_item("Z", 1'b0);
        offer_item(8'hFF, 1'b1);

        // random phases, each behind a mode write; the first two phases run
        // under a long receiver hold, one per mode
        random_base = requests_sent;
        phase_no    = 0;
        while (requests_sent - random_base < RANDOM_ITEMS)
        begin
            if (phase_no == 0)
                phase_mode = 1'b0;
            else if (phase_no == 1)
                phase_mode = 1'b1;
            else
                phase_mode = 1'($urandom_range(0, 1));
            write_mode(phase_mode);
            if (phase_no < 2)
                hold_req = 1'b1;
            phase_len   = $urandom_range(30, 70);
            phase_start = requests_sent;
            while (requests_sent - phase_start < phase_len)
            begin
                // a message without last leaves state behind for the next mode write
                if (phase_mode == 1'b0)
                    send_encode_msg($urandom_range(1, 12), $urandom_range(0, 7) != 0);
                else
                    send_decode_msg($urandom_range(1, 9), $urandom_range(0, 7) != 0,
                                    $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
            phase_no++;
        end

        drain_results();
        repeat (2 * SETTLE) @(posedge clk);
        if (shadow.errors == 0 && shadow.coded_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random stall patterns in runs of random length, long hold on request
    initial
    begin : receiver
        rx_style_t style;
        int        style_left;
        int        tick;
        out_ready  = 1'b0;
        style      = RX_ALWAYS;
        style_left = 0;
        tick       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 120);
                end
                style_left--;
                tick++;
                case (style)
                    RX_ALWAYS: out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= (tick % 4 == 0);
                    default:   out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // every accepted result is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_result(out_data);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
